[rtl/bouncing_ball_pattern_pixel_assert.svh]
// ----------------------------------------------------------------------------
// Bouncing ball pattern assertion macros
// Concurrent checks on clock and synchronous reset, shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef BOUNCING_BALL_PATTERN_PIXEL_ASSERT_SVH
`define BOUNCING_BALL_PATTERN_PIXEL_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define BBP_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define BBP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/bbp_pkg.sv]
// ----------------------------------------------------------------------------
// Bouncing ball pattern package
// Field widths, register indexes, reset values and pattern constants.
// ----------------------------------------------------------------------------
package bbp_pkg;

   // Payload and register widths
   localparam int COORD_W    = 12;
   localparam int FRAME_W    = 23;
   localparam int COLOR_W    = 8;
   localparam int RAD_W      = 12;
   localparam int DIMREG_W   = 13;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   // 6*f and 7*f for a 23-bit frame number both fit 26 bits
   localparam int MUL_W   = FRAME_W + 3;
   // Shade numerator: color times capped n, with n <= 4r
   localparam int DEN_W   = RAD_W + 2;
   localparam int SHADE_W = COLOR_W + DEN_W;
   localparam int QUO_W   = COLOR_W;

   // Color lanes of one pixel
   localparam int NUM_LANES  = 4;
   localparam int LANE_BLUE  = 0;
   localparam int LANE_GREEN = 1;
   localparam int LANE_RED   = 2;
   localparam int LANE_ALPHA = 3;

   // Register indexes on the settings port
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 3'd0,
      REG_FRAME_HEIGHT = 3'd1,
      REG_BALL_RADIUS  = 3'd2,
      REG_BALL_RED     = 3'd3,
      REG_BALL_GREEN   = 3'd4,
      REG_BALL_BLUE    = 3'd5
   } reg_index_type;

   // Register reset values
   localparam logic [DIMREG_W-1:0] FRAME_WIDTH_RST  = 13'd1920;
   localparam logic [DIMREG_W-1:0] FRAME_HEIGHT_RST = 13'd1080;
   localparam logic [RAD_W-1:0]    BALL_RADIUS_RST  = 12'd54;
   localparam logic [COLOR_W-1:0]  BALL_RED_RST     = 8'd100;
   localparam logic [COLOR_W-1:0]  BALL_GREEN_RST   = 8'd255;
   localparam logic [COLOR_W-1:0]  BALL_BLUE_RST    = 8'd50;

   // Background gray, full level, and the even-frame flash square
   localparam logic [COLOR_W-1:0] BG_LEVEL   = 8'd30;
   localparam logic [COLOR_W-1:0] FULL_LEVEL = 8'd255;
   localparam logic [COORD_W-1:0] FLASH_LO   = 12'd10;
   localparam logic [COORD_W-1:0] FLASH_HI   = 12'd25;

   // Pixel sideband carried alongside the center computation
   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic               flash;
   } pix_side_type;

endpackage

[rtl/bbp_if.sv]
// ----------------------------------------------------------------------------
// Bouncing ball pattern channels
// Valid/ready channels for pixel requests, pixel results and settings writes.
// ----------------------------------------------------------------------------
interface bbp_req_if;
   import bbp_pkg::*;
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_column;
   logic [COORD_W-1:0] pixel_row;
   logic [FRAME_W-1:0] frame_number;
   modport source (output valid, pixel_column, pixel_row, frame_number, input ready);
   modport sink (input valid, pixel_column, pixel_row, frame_number, output ready);
endinterface

interface bbp_rsp_if;
   import bbp_pkg::*;
   logic               valid;
   logic               ready;
   logic [COLOR_W-1:0] out_blue;
   logic [COLOR_W-1:0] out_green;
   logic [COLOR_W-1:0] out_red;
   logic [COLOR_W-1:0] out_alpha;
   modport source (output valid, out_blue, out_green, out_red, out_alpha, input ready);
   modport sink (input valid, out_blue, out_green, out_red, out_alpha, output ready);
endinterface

interface bbp_csr_if;
   import bbp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] write_data;
   modport source (output valid, reg_index, write_data, input ready);
   modport sink (input valid, reg_index, write_data, output ready);
endinterface

[rtl/bouncing_ball_pattern_pixel.sv]
// ----------------------------------------------------------------------------
// Bouncing ball pattern pixel generator
// Takes one pixel request per clock and returns its BGRA bytes from the output
// register, one pixel per clock sustained while the result is not stalled. The
// path is a 26-stage remainder pipeline that folds 6*f and 7*f into the bounce
// period one dividend bit per stage, followed by eight stages of center,
// distance and shade arithmetic and an 8-stage quotient pipeline that forms
// color*n/(4r) one bit per stage for all four lanes. A stalled result holds
// the whole pipeline; nothing is lost or repeated. Settings writes are
// always taken; write them only while no pixel is in flight.
// ----------------------------------------------------------------------------
`include "bouncing_ball_pattern_pixel_assert.svh"

module bouncing_ball_pattern_pixel #(
   parameter int MAX_DIMENSION = 4096
) (
   input logic        clock,
   input logic        reset,
   bbp_req_if.sink    req_chan,
   bbp_rsp_if.source  rsp_chan,
   bbp_csr_if.sink    csr_chan
);
   import bbp_pkg::*;

   // Widths that follow from the largest frame dimension
   localparam int DIM_W    = $clog2(MAX_DIMENSION + 1);
   localparam int PW       = (DIM_W > RAD_W) ? DIM_W : RAD_W;
   localparam int CW       = PW + 1;
   localparam int REMX_W   = DIM_W + 1;
   localparam int REMY_W   = DIM_W + 2;
   localparam int SQ_W     = 2 * PW;
   localparam int D2_W     = SQ_W + 1;
   localparam int R2_W     = 2 * RAD_W;
   localparam int DV_LAST  = MUL_W - 1;
   localparam int Q_LAST   = QUO_W - 1;
   localparam int F_STAGES = 8;

   // ------------------------------------------------------------------------
   // Settings registers
   // ------------------------------------------------------------------------
   logic [DIMREG_W-1:0] fw_ff;
   logic [DIMREG_W-1:0] fh_ff;
   logic [RAD_W-1:0]    rad_ff;
   logic [COLOR_W-1:0]  red_ff;
   logic [COLOR_W-1:0]  green_ff;
   logic [COLOR_W-1:0]  blue_ff;

   assign csr_chan.ready = 1'b1;

   // Write one register per transfer, drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff    <= FRAME_WIDTH_RST;
         fh_ff    <= FRAME_HEIGHT_RST;
         rad_ff   <= BALL_RADIUS_RST;
         red_ff   <= BALL_RED_RST;
         green_ff <= BALL_GREEN_RST;
         blue_ff  <= BALL_BLUE_RST;
      end else if (csr_chan.valid) begin
         case (reg_index_type'(csr_chan.reg_index))
            REG_FRAME_WIDTH:  fw_ff    <= csr_chan.write_data[DIMREG_W-1:0];
            REG_FRAME_HEIGHT: fh_ff    <= csr_chan.write_data[DIMREG_W-1:0];
            REG_BALL_RADIUS:  rad_ff   <= csr_chan.write_data[RAD_W-1:0];
            REG_BALL_RED:     red_ff   <= csr_chan.write_data[COLOR_W-1:0];
            REG_BALL_GREEN:   green_ff <= csr_chan.write_data[COLOR_W-1:0];
            REG_BALL_BLUE:    blue_ff  <= csr_chan.write_data[COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Derived settings, registered; first read two stages after entry
   // ------------------------------------------------------------------------
   logic [DIM_W-1:0] wsat_in;
   logic [DIM_W-1:0] hsat_in;
   logic [CW-1:0]    dia;
   logic             x_act_ff;
   logic             y_act_ff;
   logic [DIM_W-1:0] spx_ff;
   logic [DIM_W-1:0] spy_ff;
   logic [R2_W-1:0]  r2_ff;
   logic [REMX_W-1:0] divx;
   logic [DIM_W:0]    ampy;
   logic [REMY_W-1:0] divy;
   logic [DEN_W-1:0]  den;

   // Clamp the frame size to the largest dimension
   assign wsat_in = ({1'b0, fw_ff} > (DIMREG_W + 1)'(MAX_DIMENSION)) ?
                    DIM_W'(MAX_DIMENSION) : DIM_W'(fw_ff);
   assign hsat_in = ({1'b0, fh_ff} > (DIMREG_W + 1)'(MAX_DIMENSION)) ?
                    DIM_W'(MAX_DIMENSION) : DIM_W'(fh_ff);
   assign dia     = CW'({rad_ff, 1'b0});

   // Bounce spans, active only when positive and the ball exists
   always_ff @(posedge clock) begin
      x_act_ff <= (rad_ff != '0) && (CW'(wsat_in) > dia);
      y_act_ff <= (rad_ff != '0) && (CW'(hsat_in) > dia);
      spx_ff   <= DIM_W'(CW'(wsat_in) - dia);
      spy_ff   <= DIM_W'(CW'(hsat_in) - dia);
      r2_ff    <= R2_W'(rad_ff) * R2_W'(rad_ff);
   end

   assign divx = {spx_ff, 1'b0};
   assign ampy = {spy_ff, 1'b0};
   assign divy = {spy_ff, 2'b00};
   assign den  = {rad_ff, 2'b00};

   // ------------------------------------------------------------------------
   // Pipeline advance: move everything unless the result is stalled
   // ------------------------------------------------------------------------
   logic adv;
   logic out_vld_ff;

   assign adv            = !out_vld_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   // ------------------------------------------------------------------------
   // Entry stage and the 6f / 7f multiples
   // ------------------------------------------------------------------------
   logic               s0_vld_ff;
   logic [COORD_W-1:0] s0_x_ff;
   logic [COORD_W-1:0] s0_y_ff;
   logic [FRAME_W-1:0] s0_f_ff;
   logic               s1_vld_ff;
   logic [MUL_W-1:0]   s1_numx_ff;
   logic [MUL_W-1:0]   s1_numy_ff;
   pix_side_type       s1_side_ff;
   logic               flash_in;

   // Even frame and inside the square
   assign flash_in = !s0_f_ff[0] &&
                     (s0_x_ff inside {[FLASH_LO:FLASH_HI]}) &&
                     (s0_y_ff inside {[FLASH_LO:FLASH_HI]});

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s0_vld_ff <= req_chan.valid;
         s1_vld_ff <= s0_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_x_ff          <= req_chan.pixel_column;
         s0_y_ff          <= req_chan.pixel_row;
         s0_f_ff          <= req_chan.frame_number;
         s1_numx_ff       <= MUL_W'({s0_f_ff, 2'b00}) + MUL_W'({s0_f_ff, 1'b0});
         s1_numy_ff       <= MUL_W'({s0_f_ff, 3'b000}) - MUL_W'(s0_f_ff);
         s1_side_ff.x     <= s0_x_ff;
         s1_side_ff.y     <= s0_y_ff;
         s1_side_ff.flash <= flash_in;
      end
   end

   // ------------------------------------------------------------------------
   // Remainder pipeline: one dividend bit per stage, x and y side by side
   // ------------------------------------------------------------------------
   logic              dv_vld_ff  [MUL_W];
   logic [MUL_W-1:0]  dvx_num_ff [MUL_W];
   logic [MUL_W-1:0]  dvy_num_ff [MUL_W];
   logic [REMX_W-1:0] dvx_rem_ff [MUL_W];
   logic [REMY_W-1:0] dvy_rem_ff [MUL_W];
   pix_side_type      dv_side_ff [MUL_W];

   for (genvar k = 0; k < MUL_W; k++) begin : g_div
      logic              vld_prev;
      logic [MUL_W-1:0]  nx_prev;
      logic [MUL_W-1:0]  ny_prev;
      logic [REMX_W-1:0] rx_prev;
      logic [REMY_W-1:0] ry_prev;
      pix_side_type      side_prev;
      logic [REMX_W:0]   tx;
      logic [REMY_W:0]   ty;
      logic [REMX_W-1:0] rx_in;
      logic [REMY_W-1:0] ry_in;

      if (k == 0) begin : g_head
         assign vld_prev  = s1_vld_ff;
         assign nx_prev   = s1_numx_ff;
         assign ny_prev   = s1_numy_ff;
         assign rx_prev   = '0;
         assign ry_prev   = '0;
         assign side_prev = s1_side_ff;
      end else begin : g_body
         assign vld_prev  = dv_vld_ff[k-1];
         assign nx_prev   = dvx_num_ff[k-1];
         assign ny_prev   = dvy_num_ff[k-1];
         assign rx_prev   = dvx_rem_ff[k-1];
         assign ry_prev   = dvy_rem_ff[k-1];
         assign side_prev = dv_side_ff[k-1];
      end

      // Bring in the next dividend bit, subtract the divisor if it fits
      assign tx    = {rx_prev, nx_prev[MUL_W-1]};
      assign ty    = {ry_prev, ny_prev[MUL_W-1]};
      assign rx_in = (tx >= {1'b0, divx}) ? REMX_W'(tx - {1'b0, divx}) : tx[REMX_W-1:0];
      assign ry_in = (ty >= {1'b0, divy}) ? REMY_W'(ty - {1'b0, divy}) : ty[REMY_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[k] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dvx_num_ff[k] <= {nx_prev[MUL_W-2:0], 1'b0};
            dvy_num_ff[k] <= {ny_prev[MUL_W-2:0], 1'b0};
            dvx_rem_ff[k] <= rx_in;
            dvy_rem_ff[k] <= ry_in;
            dv_side_ff[k] <= side_prev;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Center, distance and shade numerator stages
   // ------------------------------------------------------------------------
   logic [F_STAGES-1:0] fv_ff;
   logic [DIM_W-1:0]    f1_offx_ff;
   logic [DIM_W-1:0]    f1_offy_ff;
   pix_side_type        f1_side_ff;
   logic [PW-1:0]       f2_cx_ff;
   logic [PW-1:0]       f2_cy_ff;
   pix_side_type        f2_side_ff;
   logic [PW-1:0]       f3_adx_ff;
   logic [PW-1:0]       f3_ady_ff;
   logic                f3_flash_ff;
   logic [SQ_W-1:0]     f4_sqx_ff;
   logic [SQ_W-1:0]     f4_sqy_ff;
   logic                f4_flash_ff;
   logic [D2_W-1:0]     f5_d2_ff;
   logic                f5_flash_ff;
   logic [R2_W-1:0]     f6_nraw_ff;
   logic                f6_ball_ff;
   logic                f6_flash_ff;
   logic [DEN_W-1:0]    f7_n_ff;
   logic                f7_ball_ff;
   logic                f7_flash_ff;
   logic [SHADE_W-1:0]  f8_prod_ff [NUM_LANES];
   logic                f8_ball_ff;
   logic                f8_flash_ff;

   logic [REMX_W-1:0]  px;
   logic [REMY_W-1:0]  py;
   logic [REMX_W-1:0]  foldx;
   logic [REMY_W-1:0]  foldy;
   logic [PW-1:0]      xpos;
   logic [PW-1:0]      ypos;
   logic [D2_W-1:0]    r2_ext;
   logic [COLOR_W-1:0] lane_color [NUM_LANES];

   // Fold the phase into a triangle wave
   assign px    = dvx_rem_ff[DV_LAST];
   assign py    = dvy_rem_ff[DV_LAST];
   assign foldx = (px <= REMX_W'(spx_ff)) ? px : REMX_W'(divx - px);
   assign foldy = (py <= REMY_W'(ampy)) ? py : REMY_W'(divy - py);

   assign xpos   = PW'(f2_side_ff.x);
   assign ypos   = PW'(f2_side_ff.y);
   assign r2_ext = D2_W'(r2_ff);

   assign lane_color[LANE_BLUE]  = blue_ff;
   assign lane_color[LANE_GREEN] = green_ff;
   assign lane_color[LANE_RED]   = red_ff;
   assign lane_color[LANE_ALPHA] = FULL_LEVEL;

   always_ff @(posedge clock) begin
      if (reset) begin
         fv_ff <= '0;
      end else if (adv) begin
         fv_ff <= {fv_ff[F_STAGES-2:0], dv_vld_ff[DV_LAST]};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // Offsets from the radius; rows come back from half pixels
         f1_offx_ff  <= x_act_ff ? DIM_W'(foldx) : '0;
         f1_offy_ff  <= y_act_ff ? foldy[DIM_W:1] : '0;
         f1_side_ff  <= dv_side_ff[DV_LAST];
         // Ball center
         f2_cx_ff    <= PW'(rad_ff) + PW'(f1_offx_ff);
         f2_cy_ff    <= PW'(rad_ff) + PW'(f1_offy_ff);
         f2_side_ff  <= f1_side_ff;
         // Absolute offsets from the center
         f3_adx_ff   <= (xpos >= f2_cx_ff) ? xpos - f2_cx_ff : f2_cx_ff - xpos;
         f3_ady_ff   <= (ypos >= f2_cy_ff) ? ypos - f2_cy_ff : f2_cy_ff - ypos;
         f3_flash_ff <= f2_side_ff.flash;
         // Squares
         f4_sqx_ff   <= SQ_W'(f3_adx_ff) * SQ_W'(f3_adx_ff);
         f4_sqy_ff   <= SQ_W'(f3_ady_ff) * SQ_W'(f3_ady_ff);
         f4_flash_ff <= f3_flash_ff;
         // Squared distance
         f5_d2_ff    <= D2_W'(f4_sqx_ff) + D2_W'(f4_sqy_ff);
         f5_flash_ff <= f4_flash_ff;
         // Inside the disc, and how deep
         f6_nraw_ff  <= R2_W'(r2_ext - f5_d2_ff);
         f6_ball_ff  <= (f5_d2_ff <= r2_ext) && (rad_ff != '0);
         f6_flash_ff <= f5_flash_ff;
         // Cap the depth at 4r
         f7_n_ff     <= (f6_nraw_ff > R2_W'(den)) ? den : DEN_W'(f6_nraw_ff);
         f7_ball_ff  <= f6_ball_ff;
         f7_flash_ff <= f6_flash_ff;
         // Shade numerators
         for (int l = 0; l < NUM_LANES; l++) begin
            f8_prod_ff[l] <= SHADE_W'(lane_color[l]) * SHADE_W'(f7_n_ff);
         end
         f8_ball_ff  <= f7_ball_ff;
         f8_flash_ff <= f7_flash_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Quotient pipeline: one quotient bit per stage for all four lanes
   // ------------------------------------------------------------------------
   logic               q_vld_ff   [QUO_W];
   logic               q_ball_ff  [QUO_W];
   logic               q_flash_ff [QUO_W];
   logic [SHADE_W-1:0] q_rem_ff   [QUO_W][NUM_LANES];
   logic [QUO_W-1:0]   q_quo_ff   [QUO_W][NUM_LANES];

   for (genvar j = 0; j < QUO_W; j++) begin : g_quo
      logic               vld_prev;
      logic               ball_prev;
      logic               flash_prev;
      logic [SHADE_W-1:0] rem_prev [NUM_LANES];
      logic [QUO_W-1:0]   quo_prev [NUM_LANES];
      logic [SHADE_W-1:0] dsh;

      if (j == 0) begin : g_head
         assign vld_prev   = fv_ff[F_STAGES-1];
         assign ball_prev  = f8_ball_ff;
         assign flash_prev = f8_flash_ff;
         always_comb begin
            for (int l = 0; l < NUM_LANES; l++) begin
               rem_prev[l] = f8_prod_ff[l];
               quo_prev[l] = '0;
            end
         end
      end else begin : g_body
         assign vld_prev   = q_vld_ff[j-1];
         assign ball_prev  = q_ball_ff[j-1];
         assign flash_prev = q_flash_ff[j-1];
         always_comb begin
            for (int l = 0; l < NUM_LANES; l++) begin
               rem_prev[l] = q_rem_ff[j-1][l];
               quo_prev[l] = q_quo_ff[j-1][l];
            end
         end
      end

      // Divisor aligned to this stage's quotient bit
      assign dsh = SHADE_W'(den) << (QUO_W - 1 - j);

      always_ff @(posedge clock) begin
         if (reset) begin
            q_vld_ff[j] <= 1'b0;
         end else if (adv) begin
            q_vld_ff[j] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            q_ball_ff[j]  <= ball_prev;
            q_flash_ff[j] <= flash_prev;
            for (int l = 0; l < NUM_LANES; l++) begin
               if (rem_prev[l] >= dsh) begin
                  q_rem_ff[j][l] <= rem_prev[l] - dsh;
                  q_quo_ff[j][l] <= {quo_prev[l][QUO_W-2:0], 1'b1};
               end else begin
                  q_rem_ff[j][l] <= rem_prev[l];
                  q_quo_ff[j][l] <= {quo_prev[l][QUO_W-2:0], 1'b0};
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Output register: flash over ball over background
   // ------------------------------------------------------------------------
   logic [COLOR_W-1:0] out_lane_ff [NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         out_vld_ff <= q_vld_ff[Q_LAST];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int l = 0; l < NUM_LANES; l++) begin
            if (q_flash_ff[Q_LAST]) begin
               out_lane_ff[l] <= FULL_LEVEL;
            end else if (q_ball_ff[Q_LAST]) begin
               out_lane_ff[l] <= q_quo_ff[Q_LAST][l];
            end else begin
               out_lane_ff[l] <= (l == LANE_ALPHA) ? FULL_LEVEL : BG_LEVEL;
            end
         end
      end
   end

   assign rsp_chan.valid     = out_vld_ff;
   assign rsp_chan.out_blue  = out_lane_ff[LANE_BLUE];
   assign rsp_chan.out_green = out_lane_ff[LANE_GREEN];
   assign rsp_chan.out_red   = out_lane_ff[LANE_RED];
   assign rsp_chan.out_alpha = out_lane_ff[LANE_ALPHA];

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   `BBP_ASSERT_SAME(a_rem_x_below_div, clock, reset, dv_vld_ff[DV_LAST] && x_act_ff,
      dvx_rem_ff[DV_LAST] < divx, "column phase not below bounce period")
   `BBP_ASSERT_SAME(a_rem_y_below_div, clock, reset, dv_vld_ff[DV_LAST] && y_act_ff,
      dvy_rem_ff[DV_LAST] < divy, "row phase not below bounce period")
   `BBP_ASSERT_SAME(a_shade_blue_cap, clock, reset, q_vld_ff[Q_LAST] && q_ball_ff[Q_LAST],
      q_quo_ff[Q_LAST][LANE_BLUE] <= blue_ff, "shaded blue above full shade")
   `BBP_ASSERT_NEXT(a_stall_holds_mid, clock, reset, !adv,
      $stable(fv_ff), "stage valids moved during a stall")

endmodule
